// ===== rtl/core/coi_pkg.sv =====
// Shared constants, types and the cell scaling function of the costmap inflation block.
`default_nettype none
package coi_pkg;

    localparam int MAX_CELLS = 65536;
    localparam int ADDR_W    = $clog2(MAX_CELLS);
    localparam int CFG_W     = 17;
    localparam int PASS_W    = 8;
    localparam int CELL_W    = 8;
    localparam int WORD_W    = CELL_W + 1;
    localparam int CMP_W     = (ADDR_W + 1 > CFG_W) ? ADDR_W + 1 : CFG_W;
    localparam int SUM_W     = CMP_W + 1;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] REG_ROW_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CELL_COUNT = 2'd1;
    localparam logic [1:0] REG_PASS_COUNT = 2'd2;

    localparam logic [CFG_W-1:0]  ROW_WIDTH_RST  = CFG_W'(256);
    localparam logic [CFG_W-1:0]  CELL_COUNT_RST = CFG_W'(65536);
    localparam logic [PASS_W-1:0] PASS_COUNT_RST = PASS_W'(20);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } coi_state_t;

    // Returns 9*v/10 rounded toward zero; the divide by ten is a reciprocal multiply.
    function automatic logic [CELL_W-1:0] scale_cell(input logic [CELL_W-1:0] v);
        logic              neg;
        logic [CELL_W-1:0] mag;
        logic [10:0]       prod;
        logic [26:0]       quot;
        logic [CELL_W-1:0] res;
        neg  = v[CELL_W-1];
        mag  = neg ? CELL_W'(-v) : v;
        prod = 11'(mag) * 11'd9;
        quot = (27'(prod) * 27'd52429) >> 19;
        res  = quot[CELL_W-1:0];
        return neg ? CELL_W'(-res) : res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/costmap_obstacle_inflation.sv =====
// Costmap obstacle inflation: grid storage in two banks, cell access and the pass sequencer.
// A cell write or read is taken one per cycle while idle and not stalled at the output; its
// result passes the pending register, then the output register. In a run each cell needs five
// reads of one bank's read port (self and four neighbors) and one write into the other bank.
// Reset restores row_width 256, cell_count 65536 and pass_count 20 and empties the pipeline;
// grid contents and free marks are not cleared and hold nothing defined until written.
`default_nettype none
module costmap_obstacle_inflation (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [coi_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [23:0]                s_tdata,   // cell_index[15:0], cell_value[23:16]
    input  wire logic [1:0]                 s_tuser,   // cmd[1:0]
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [7:0]                 m_tdata,   // read_value[7:0]
    output logic      [0:0]                 m_tuser    // status[0]
);
    import coi_pkg::*;

    coi_state_t state_reg, state_next;

    logic [CFG_W-1:0]  row_width_reg, cell_count_reg;
    logic [PASS_W-1:0] pass_count_reg;

    logic              bank_reg, bank_next;
    logic [PASS_W-1:0] pass_cnt_reg, pass_cnt_next;
    logic [ADDR_W-1:0] cell_reg, cell_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [2:0]        ph_reg, ph_next;
    logic              nb_ok_reg, nb_ok_next;
    logic [WORD_W-1:0] self_reg, self_next;
    logic              hit_reg, hit_next;
    logic [CELL_W-1:0] val_reg, val_next;

    logic pend_valid_reg, pend_valid_next;
    logic pend_read_reg, pend_read_next;
    logic pend_status_reg, pend_status_next;
    logic out_valid_reg, out_valid_next;
    logic [CELL_W-1:0] out_data_reg, out_data_next;
    logic out_status_reg, out_status_next;

    logic [1:0]        in_cmd;
    logic [15:0]       in_idx;
    logic [CELL_W-1:0] in_val;
    logic [CMP_W-1:0]  n_eff, w_eff;
    logic [SUM_W-1:0]  cell_ext, col_ext, n_ext, w_ext;
    logic              idx_ok, accept, out_free, pend_move, run_empty;
    logic              scan_rd, scan_wr, cmd_wr, cmd_rd, last_cell;
    logic [ADDR_W-1:0] scan_addr, ram_raddr, ram_waddr;
    logic              scan_ok;
    logic [WORD_W-1:0] ram_wdata, rdata_a, rdata_b, rd_word;
    logic              we_a, we_b, re_a, re_b;
    logic [CELL_W-1:0] scaled_val;

    assign in_cmd = s_tuser;
    assign in_idx = s_tdata[15:0];
    assign in_val = s_tdata[23:16];

    assign n_eff = (CMP_W'(cell_count_reg) > CMP_W'(MAX_CELLS)) ? CMP_W'(MAX_CELLS)
                                                                : CMP_W'(cell_count_reg);
    assign w_eff = (row_width_reg == '0) ? CMP_W'(1) : CMP_W'(row_width_reg);
    assign cell_ext = SUM_W'(cell_reg);
    assign col_ext  = SUM_W'(col_reg);
    assign n_ext    = SUM_W'(n_eff);
    assign w_ext    = SUM_W'(w_eff);

    assign idx_ok    = CMP_W'(in_idx) < n_eff;
    assign out_free  = !out_valid_reg || m_tready;
    assign pend_move = pend_valid_reg && out_free;
    assign accept    = s_tvalid && s_tready;
    assign run_empty = (n_eff == '0) || (pass_count_reg == '0);
    assign last_cell = (cell_ext + SUM_W'(1)) == n_ext;
    assign rd_word   = bank_reg ? rdata_b : rdata_a;
    assign scaled_val = scale_cell(val_reg);

    always_comb begin
        scan_addr = cell_reg;
        scan_ok   = 1'b0;
        case (ph_reg)
            3'd0: begin
                scan_addr = cell_reg;
                scan_ok   = 1'b1;
            end
            3'd1: begin
                scan_addr = ADDR_W'(cell_ext - SUM_W'(1));
                scan_ok   = col_reg != '0;
            end
            3'd2: begin
                scan_addr = ADDR_W'(cell_ext + SUM_W'(1));
                scan_ok   = (col_ext + SUM_W'(1) < w_ext) && (cell_ext + SUM_W'(1) < n_ext);
            end
            3'd3: begin
                scan_addr = ADDR_W'(cell_ext - w_ext);
                scan_ok   = cell_ext >= w_ext;
            end
            3'd4: begin
                scan_addr = ADDR_W'(cell_ext + w_ext);
                scan_ok   = (cell_ext + w_ext) < n_ext;
            end
            default: begin
                scan_addr = cell_reg;
                scan_ok   = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && in_cmd == CMD_RUN) begin
                    state_next = run_empty ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (ph_reg == 3'd6 && last_cell &&
                    (9'(pass_cnt_reg) + 9'd1) == 9'(pass_count_reg)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        scan_rd  = 1'b0;
        scan_wr  = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = !pend_valid_reg || out_free;
            ST_SCAN: begin
                scan_rd = ph_reg <= 3'd4;
                scan_wr = ph_reg == 3'd6;
            end
            ST_DONE: s_tready = 1'b0;
            default: s_tready = 1'b0;
        endcase
    end

    assign cmd_wr = accept && in_cmd == CMD_WRITE && idx_ok;
    assign cmd_rd = accept && in_cmd == CMD_READ && idx_ok;

    assign ram_raddr = scan_rd ? scan_addr : ADDR_W'(in_idx);
    assign re_a      = (scan_rd || cmd_rd) && !bank_reg;
    assign re_b      = (scan_rd || cmd_rd) && bank_reg;
    assign we_a      = cmd_wr || (scan_wr && bank_reg);
    assign we_b      = cmd_wr || (scan_wr && !bank_reg);
    assign ram_waddr = scan_wr ? cell_reg : ADDR_W'(in_idx);

    always_comb begin
        if (scan_wr) begin
            ram_wdata = (self_reg[CELL_W] && hit_reg) ? {1'b0, scaled_val} : self_reg;
        end else begin
            ram_wdata = {in_val == '0, in_val};
        end
    end

    always_comb begin
        bank_next     = bank_reg;
        pass_cnt_next = pass_cnt_reg;
        cell_next     = cell_reg;
        col_next      = col_reg;
        ph_next       = ph_reg;
        nb_ok_next    = nb_ok_reg;
        self_next     = self_reg;
        hit_next      = hit_reg;
        val_next      = val_reg;
        if (accept && in_cmd == CMD_RUN) begin
            pass_cnt_next = '0;
            cell_next     = '0;
            col_next      = '0;
            ph_next       = '0;
            hit_next      = 1'b0;
        end else if (state_reg == ST_SCAN) begin
            nb_ok_next = scan_ok;
            if (ph_reg == 3'd0) begin
                hit_next = 1'b0;
            end else if (ph_reg == 3'd1) begin
                self_next = rd_word;
            end else if (ph_reg <= 3'd5) begin
                if (nb_ok_reg && !hit_reg && rd_word[CELL_W-1:0] != '0) begin
                    hit_next = 1'b1;
                    val_next = rd_word[CELL_W-1:0];
                end
            end
            if (ph_reg == 3'd6) begin
                ph_next = '0;
                if (last_cell) begin
                    bank_next     = !bank_reg;
                    cell_next     = '0;
                    col_next      = '0;
                    pass_cnt_next = pass_cnt_reg + PASS_W'(1);
                end else begin
                    cell_next = cell_reg + ADDR_W'(1);
                    col_next  = ((col_ext + SUM_W'(1)) == w_ext) ? '0 : col_reg + ADDR_W'(1);
                end
            end else begin
                ph_next = ph_reg + 3'd1;
            end
        end
    end

    always_comb begin
        pend_valid_next  = pend_valid_reg;
        pend_read_next   = pend_read_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_status_next  = out_status_reg;
        if (pend_move) begin
            out_valid_next  = 1'b1;
            out_data_next   = pend_read_reg ? rd_word[CELL_W-1:0] : '0;
            out_status_next = pend_status_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (accept && in_cmd != CMD_RUN) begin
            pend_valid_next  = 1'b1;
            pend_read_next   = cmd_rd;
            pend_status_next = (in_cmd == CMD_WRITE || in_cmd == CMD_READ) && !idx_ok;
        end else if (state_reg == ST_DONE && (!pend_valid_reg || out_free)) begin
            pend_valid_next  = 1'b1;
            pend_read_next   = 1'b0;
            pend_status_next = 1'b0;
        end else if (pend_move) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            row_width_reg  <= ROW_WIDTH_RST;
            cell_count_reg <= CELL_COUNT_RST;
            pass_count_reg <= PASS_COUNT_RST;
            bank_reg       <= 1'b0;
            pass_cnt_reg   <= '0;
            cell_reg       <= '0;
            col_reg        <= '0;
            ph_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            bank_reg       <= bank_next;
            pass_cnt_reg   <= pass_cnt_next;
            cell_reg       <= cell_next;
            col_reg        <= col_next;
            ph_reg         <= ph_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_ROW_WIDTH:  row_width_reg  <= cfg_wdata;
                    REG_CELL_COUNT: cell_count_reg <= cfg_wdata;
                    REG_PASS_COUNT: pass_count_reg <= cfg_wdata[PASS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        nb_ok_reg       <= nb_ok_next;
        self_reg        <= self_next;
        hit_reg         <= hit_next;
        val_reg         <= val_next;
        pend_read_reg   <= pend_read_next;
        pend_status_reg <= pend_status_next;
        out_data_reg    <= out_data_next;
        out_status_reg  <= out_status_next;
    end

    coi_ram #(
        .DATA_W(WORD_W),
        .DEPTH (MAX_CELLS)
    ) u_bank_a (
        .clk  (aclk),
        .we   (we_a),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (re_a),
        .raddr(ram_raddr),
        .rdata(rdata_a)
    );

    coi_ram #(
        .DATA_W(WORD_W),
        .DEPTH (MAX_CELLS)
    ) u_bank_b (
        .clk  (aclk),
        .we   (we_b),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (re_b),
        .raddr(ram_raddr),
        .rdata(rdata_b)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> ph_reg <= 3'd6)
        else $error("scan phase out of range");

    a_pass_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> pass_cnt_reg < pass_count_reg)
        else $error("pass counter passed the pass count");

    a_cell_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> CMP_W'(cell_reg) < n_eff)
        else $error("scan cell beyond the grid");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("error result carries a nonzero value");

    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg && out_valid_reg && !m_tready |=> pend_valid_reg)
        else $error("pending result lost while output stalled");

endmodule
`default_nettype wire

// ===== rtl/core/coi_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module coi_ram #(
    parameter int DATA_W = 9,
    parameter int DEPTH  = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire
